// ----- src/kwtm_pkg.sv -----
// shared widths, codes and the stored event word of the timestamp merge core
package kwtm_pkg;

  localparam int TIME_W   = 32;
  localparam int TYPE_W   = 8;
  localparam int COST_W   = 32;
  localparam int LINE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 12;

  localparam logic [LIMIT_W-1:0] MERGE_LIMIT_RESET = 12'd2048;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [TYPE_W-1:0] ptype;
    logic [COST_W-1:0] cost;
  } event_t;

endpackage

// ----- src/kwtm_in_if.sv -----
// input channel: append or pop request words
interface kwtm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [kwtm_pkg::LINE_W-1:0] line;
  logic [kwtm_pkg::TIME_W-1:0] timestamp;
  logic [kwtm_pkg::TYPE_W-1:0] packet_type;
  logic [kwtm_pkg::COST_W-1:0] service_cost;

  modport source (output valid, mode, line, timestamp, packet_type, service_cost,
                  input ready);
  modport sink (input valid, mode, line, timestamp, packet_type, service_cost,
                output ready);
endinterface

// ----- src/kwtm_out_if.sv -----
// output channel: one result word per request
interface kwtm_out_if;
  logic                          valid;
  logic                          ready;
  logic [kwtm_pkg::STATUS_W-1:0] status;
  logic [kwtm_pkg::LINE_W-1:0]   source_line;
  logic [kwtm_pkg::TIME_W-1:0]   event_time;
  logic [kwtm_pkg::TYPE_W-1:0]   event_type;
  logic [kwtm_pkg::COST_W-1:0]   event_cost;

  modport source (output valid, status, source_line, event_time, event_type, event_cost,
                  input ready);
  modport sink (input valid, status, source_line, event_time, event_type, event_cost,
                output ready);
endinterface

// ----- src/kway_timestamp_merge_core.sv -----
// top level of the k-way timestamp merge core
//
// evt_i takes request words: mode 0 appends an event (timestamp, type, cost)
// at the tail of the named line, mode 1 pops the pending head event with the
// smallest timestamp over all lines, the lowest line winning a tie.
// res_o returns exactly one result word per request, in request order.
// an append, a drop and a pop once the merge limit is reached go straight
// to the done state; a pop that scans the lines steps through the scan,
// last and fin states, reading one line head a cycle from the event ram
// and comparing it against the running minimum.
// one request is worked on at a time; a finished result moves into the
// output register, so the next request is taken while the result waits.
// if the receiver stalls with a result still held, the next result waits
// in its final state and no further request is taken.
// reset empties every line, clears the pop count and sets merge_limit to
// 2048; the event ram needs no clearing since only written entries are read.
// cfg_we_i writes merge_limit; the user must assert it only while no request
// is in flight, a rule that the block itself leaves unchecked.
module kway_timestamp_merge_core #(
  parameter int NUM_LINES  = 8,
  parameter int LINE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kwtm_in_if.sink                      evt_i,
  kwtm_out_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [kwtm_pkg::LIMIT_W-1:0] cfg_wdata_i
);

  localparam int LW = $clog2(NUM_LINES);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int PW = $clog2(LINE_DEPTH);
  localparam int DEPTH = NUM_LINES * LINE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int EW = $bits(kwtm_pkg::event_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] ln,
                                               input logic [CW-1:0] pos);
    slot_addr = AW'(ln) * AW'(LINE_DEPTH) + AW'(PW'(pos));
  endfunction

  logic [2:0]                      state_q, state_d;
  logic [CW-1:0]                   wcnt_q [NUM_LINES];
  logic [CW-1:0]                   rpos_q [NUM_LINES];
  logic [kwtm_pkg::LIMIT_W-1:0]    emitted_q;
  logic [kwtm_pkg::LIMIT_W-1:0]    limit_q;
  logic [LW-1:0]                   idx_q;
  logic                            rd_vld_q;
  logic [LW-1:0]                   rd_line_q;
  logic                            found_q;
  logic [LW-1:0]                   best_line_q;
  kwtm_pkg::event_t                best_q;
  logic [kwtm_pkg::STATUS_W-1:0]   res_status_q;
  logic [kwtm_pkg::LINE_W-1:0]     res_line_q;
  kwtm_pkg::event_t                res_evt_q;
  logic                            out_valid_q;
  logic [kwtm_pkg::STATUS_W-1:0]   out_status_q;
  logic [kwtm_pkg::LINE_W-1:0]     out_line_q;
  kwtm_pkg::event_t                out_evt_q;

  logic [NUM_LINES-1:0] nonempty;
  logic                 accept;
  logic                 is_pop;
  logic [LW-1:0]        in_line;
  logic                 line_ok;
  logic                 line_full;
  logic                 do_write;
  logic                 limit_hit;
  logic                 take;
  logic                 out_free;
  logic                 last_idx;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  kwtm_pkg::event_t     wdata;
  kwtm_pkg::event_t     rdata;
  logic [EW-1:0]        rdata_raw;

  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      nonempty[i] = rpos_q[i] < wcnt_q[i];
    end
  end

  assign accept    = evt_i.valid && evt_i.ready;
  assign is_pop    = evt_i.mode == kwtm_pkg::MODE_POP;
  assign in_line   = LW'(evt_i.line);
  assign line_ok   = 32'(evt_i.line) < NUM_LINES;
  assign line_full = line_ok && (wcnt_q[in_line] == CW'(LINE_DEPTH));
  assign do_write  = accept && !is_pop && line_ok && !line_full;
  assign limit_hit = emitted_q >= limit_q;
  assign out_free  = !out_valid_q || res_o.ready;
  assign last_idx  = idx_q == LW'(NUM_LINES - 1);
  assign evt_i.ready = state_q == S_IDLE;

  assign waddr = slot_addr(in_line, wcnt_q[in_line]);
  assign raddr = slot_addr(idx_q, rpos_q[idx_q]);
  assign wdata = '{ts: evt_i.timestamp, ptype: evt_i.packet_type, cost: evt_i.service_cost};
  assign rdata = kwtm_pkg::event_t'(rdata_raw);
  assign take  = rd_vld_q && (!found_q || (rdata.ts < best_q.ts));

  kwtm_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_evt_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (waddr),
    .wdata_i (EW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (is_pop && !limit_hit) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emitted_q   <= '0;
      limit_q     <= kwtm_pkg::MERGE_LIMIT_RESET;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        wcnt_q[i] <= '0;
        rpos_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_SCAN) && nonempty[idx_q];
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (do_write) begin
        wcnt_q[in_line] <= wcnt_q[in_line] + CW'(1);
      end
      if (state_q == S_IDLE) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == S_SCAN && !last_idx) begin
        idx_q <= idx_q + LW'(1);
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (state_q == S_FIN && found_q) begin
        rpos_q[best_line_q] <= rpos_q[best_line_q] + CW'(1);
        emitted_q           <= emitted_q + kwtm_pkg::LIMIT_W'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rd_line_q <= idx_q;
    if (take) begin
      best_q      <= rdata;
      best_line_q <= rd_line_q;
    end
    if (state_q == S_IDLE && accept) begin
      res_evt_q <= '0;
      if (is_pop) begin
        res_status_q <= kwtm_pkg::ST_EMPTY;
        res_line_q   <= '0;
      end else begin
        res_status_q <= do_write ? kwtm_pkg::ST_APPENDED : kwtm_pkg::ST_DROPPED;
        res_line_q   <= evt_i.line;
      end
    end else if (state_q == S_FIN) begin
      if (found_q) begin
        res_status_q <= kwtm_pkg::ST_POPPED;
        res_line_q   <= kwtm_pkg::LINE_W'(best_line_q);
        res_evt_q    <= best_q;
      end else begin
        res_status_q <= kwtm_pkg::ST_EMPTY;
        res_line_q   <= '0;
        res_evt_q    <= '0;
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_line_q   <= res_line_q;
      out_evt_q    <= res_evt_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.source_line = out_line_q;
  assign res_o.event_time  = out_evt_q.ts;
  assign res_o.event_type  = out_evt_q.ptype;
  assign res_o.event_cost  = out_evt_q.cost;

endmodule

// ----- src/kwtm_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module kwtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
